FILE: design/nrfp_pkg.sv
// ----------------------------------------------------------------------------
// nrfp_pkg: shared types and constants of the response frame parser
// Parse phases, completion codes, beat structs and configuration layout.
// ----------------------------------------------------------------------------
package nrfp_pkg;

  // Byte values seen on the link
  localparam logic [7:0] BYTE_00   = 8'h00;
  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] ERR_FORM  = 8'h01;
  localparam logic [7:0] TFI_RESP  = 8'hD5;

  // Configuration port layout
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_COMMAND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD_LEN  = 1'b1;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd264;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_PRE1,
    PH_PRE2,
    PH_FORM1,
    PH_FORM2,
    PH_ESKIP,
    PH_EXTHI,
    PH_EXTLO,
    PH_EXTLCS,
    PH_TFI,
    PH_CMD,
    PH_DATA,
    PH_DCS,
    PH_POST
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_PREAMBLE  = 4'd1,
    ST_APP_ERR   = 4'd2,
    ST_LEN_CSUM  = 4'd3,
    ST_TOO_LONG  = 4'd4,
    ST_TFI       = 4'd5,
    ST_CMD       = 4'd6,
    ST_DATA_CSUM = 4'd7,
    ST_POSTAMBLE = 4'd8
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        done_res;
    status_t     status;
    logic [15:0] payload_len;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]  expected_command;
    logic [15:0] max_payload_len;
  } cfg_t;

endpackage

FILE: design/nrfp_in_if.sv
// ----------------------------------------------------------------------------
// nrfp_in_if: received byte channel
// Valid/ready channel carrying one received byte and its frame start mark.
// ----------------------------------------------------------------------------
interface nrfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

FILE: design/nrfp_out_if.sv
// ----------------------------------------------------------------------------
// nrfp_out_if: parser result channel
// Valid/ready channel carrying payload pass-through and frame completion.
// ----------------------------------------------------------------------------
interface nrfp_out_if;
  logic        valid;
  logic        ready;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic        done_res;
  logic [3:0]  status;
  logic [15:0] payload_len;

  modport source (output valid, output data_valid, output data_byte, output done_res,
                  output status, output payload_len, input ready);
  modport sink   (input valid, input data_valid, input data_byte, input done_res,
                  input status, input payload_len, output ready);
endinterface

FILE: design/nfc_response_frame_parser_core.sv
// ----------------------------------------------------------------------------
// nfc_response_frame_parser_core: controller response frame parser
// Input register, parse state machine and result register for one byte/beat.
// ----------------------------------------------------------------------------
// Usage:
//   rx    - one received byte per beat; frame_start marks the first byte of
//           a response and restarts the parser at any point.
//   res   - one result per input beat: a passed-through payload byte
//           (data_valid), a frame end (done_res with status, and payload_len
//           on success), or an all-zero beat for framing bytes.
//   cfg_* - register writes (expected command, payload length limit), made
//           while no beat is in flight.
// Pipeline: the accepting edge loads the input register, and the result
// register is loaded from it once the result side can advance.
// Throughput: one byte per cycle while res is not held; the parse state
// machine updates its phase, counters and checksums once per byte.
// Reset: synchronous; clears both pipeline valid flags, returns the parser to
// waiting for a frame start and loads the register reset values.
// Stall: while res is held, the input register keeps one more byte and rx
// ready drops until the result beat is taken; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module nfc_response_frame_parser_core
  import nrfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  nrfp_in_if.sink               rx,
  nrfp_out_if.source            res
);

  cfg_t      cfg;
  in_beat_t  in_q;
  logic      in_q_valid;
  logic      out_valid;
  out_beat_t res_q;
  out_beat_t result;
  logic      advance;
  logic      fire;

  // Configuration registers
  nrfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Pipeline control: result register free or being drained
  assign advance  = !out_valid || res.ready;
  assign fire     = in_q_valid && advance;
  assign rx.ready = !in_q_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (rx.ready) begin
      in_q_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_q.rx_byte     <= rx.rx_byte;
      in_q.frame_start <= rx.frame_start;
    end
  end

  // Parse state machine
  nrfp_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .beat   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= result;
    end
  end

  assign res.valid       = out_valid;
  assign res.data_valid  = res_q.data_valid;
  assign res.data_byte   = res_q.data_byte;
  assign res.done_res    = res_q.done_res;
  assign res.status      = res_q.status;
  assign res.payload_len = res_q.payload_len;

`ifndef SYNTHESIS
  // A beat is either a payload byte or a frame end, never both
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.data_valid && res.done_res))
    else $error("payload byte and frame end in one beat");

  // Status and length are zero unless the beat ends a frame
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.done_res |-> res.status == ST_OK && res.payload_len == '0)
    else $error("status or length set without frame end");

  // A waiting input byte is held while the result side is stalled
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !advance |=> in_q_valid && $stable(in_q))
    else $error("input register lost a byte under stall");
`endif

endmodule

FILE: design/nrfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// nrfp_cfg_regs: configuration registers
// Decodes the write port into the expected command and payload length limit.
// ----------------------------------------------------------------------------
module nrfp_cfg_regs
  import nrfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  // Register write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_command <= '0;
      cfg.max_payload_len  <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPECTED_COMMAND: cfg.expected_command <= cfg_wdata[7:0];
        CFG_MAX_PAYLOAD_LEN:  cfg.max_payload_len  <= cfg_wdata[15:0];
      endcase
    end
  end

endmodule

FILE: design/nrfp_parser.sv
// ----------------------------------------------------------------------------
// nrfp_parser: frame parse state machine
// Holds the parse phase, counters and running sums; forms one result per beat.
// ----------------------------------------------------------------------------
module nrfp_parser
  import nrfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_beat_t  beat,
  input  cfg_t      cfg,
  output out_beat_t result
);

  phase_t      phase, phase_next;
  logic [15:0] remaining_count, remaining_count_next;
  logic [15:0] length_value, length_value_next;
  logic [7:0]  length_sum, length_sum_next;
  logic [7:0]  data_sum, data_sum_next;
  logic [1:0]  skip_count, skip_count_next;

  logic [7:0]  b;
  logic [15:0] len_sel;
  logic [15:0] len_m2;
  logic        len_bad;
  logic [8:0]  norm_sum;
  logic [7:0]  ext_sum;
  logic [8:0]  cmd_want;
  logic [7:0]  data_sum_add;
  logic [15:0] remaining_dec;

  assign b = beat.rx_byte;

  // Shared length check: normal LEN or extended 16-bit length
  assign len_sel  = (phase == PH_EXTLCS) ? length_value : {8'h00, length_sum};
  assign len_m2   = len_sel - 16'd2;
  assign len_bad  = (len_sel < 16'd2) || (len_m2 > cfg.max_payload_len);

  assign norm_sum      = {1'b0, length_sum} + {1'b0, b};
  assign ext_sum       = length_sum + b;
  assign cmd_want      = {1'b0, cfg.expected_command} + 9'd1;
  assign data_sum_add  = data_sum + b;
  assign remaining_dec = remaining_count - 16'd1;

  // State registers, advanced once per processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      remaining_count <= '0;
      length_value    <= '0;
      length_sum      <= '0;
      data_sum        <= '0;
      skip_count      <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      remaining_count <= remaining_count_next;
      length_value    <= length_value_next;
      length_sum      <= length_sum_next;
      data_sum        <= data_sum_next;
      skip_count      <= skip_count_next;
    end
  end

  // Next state and result
  always_comb begin
    phase_next           = phase;
    remaining_count_next = remaining_count;
    length_value_next    = length_value;
    length_sum_next      = length_sum;
    data_sum_next        = data_sum;
    skip_count_next      = skip_count;
    result               = '0;
    result.status        = ST_OK;

    if (beat.frame_start) begin
      if (b == BYTE_00) begin
        phase_next = PH_PRE1;
      end else begin
        result.done_res = 1'b1;
        result.status   = ST_PREAMBLE;
        phase_next      = PH_IDLE;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        PH_PRE1: begin
          priority if (b == BYTE_FF) begin
            phase_next = PH_FORM1;
          end else if (b == BYTE_00) begin
            phase_next = PH_PRE2;
          end else begin
            result.done_res = 1'b1;
            result.status   = ST_PREAMBLE;
            phase_next      = PH_IDLE;
          end
        end
        PH_PRE2: begin
          if (b == BYTE_FF) begin
            phase_next = PH_FORM1;
          end else begin
            result.done_res = 1'b1;
            result.status   = ST_PREAMBLE;
            phase_next      = PH_IDLE;
          end
        end
        PH_FORM1: begin
          length_sum_next = b;
          phase_next      = PH_FORM2;
        end
        PH_FORM2: begin
          priority if (length_sum == ERR_FORM && b == BYTE_FF) begin
            skip_count_next = '0;
            phase_next      = PH_ESKIP;
          end else if (length_sum == BYTE_FF && b == BYTE_FF) begin
            phase_next = PH_EXTHI;
          end else if (norm_sum != 9'd256) begin
            result.done_res = 1'b1;
            result.status   = ST_LEN_CSUM;
            phase_next      = PH_IDLE;
          end else if (len_bad) begin
            result.done_res = 1'b1;
            result.status   = ST_TOO_LONG;
            phase_next      = PH_IDLE;
          end else begin
            length_value_next    = len_m2;
            remaining_count_next = len_m2;
            phase_next           = PH_TFI;
          end
        end
        PH_ESKIP: begin
          if (skip_count >= 2'd2) begin
            skip_count_next = '0;
            result.done_res = 1'b1;
            result.status   = ST_APP_ERR;
            phase_next      = PH_IDLE;
          end else begin
            skip_count_next = skip_count + 2'd1;
          end
        end
        PH_EXTHI: begin
          length_value_next = {8'h00, b};
          length_sum_next   = b;
          phase_next        = PH_EXTLO;
        end
        PH_EXTLO: begin
          length_value_next = {length_value[7:0], b};
          length_sum_next   = ext_sum;
          phase_next        = PH_EXTLCS;
        end
        PH_EXTLCS: begin
          priority if (ext_sum != 8'h00) begin
            result.done_res = 1'b1;
            result.status   = ST_LEN_CSUM;
            phase_next      = PH_IDLE;
          end else if (len_bad) begin
            result.done_res = 1'b1;
            result.status   = ST_TOO_LONG;
            phase_next      = PH_IDLE;
          end else begin
            length_value_next    = len_m2;
            remaining_count_next = len_m2;
            phase_next           = PH_TFI;
          end
        end
        PH_TFI: begin
          if (b != TFI_RESP) begin
            result.done_res = 1'b1;
            result.status   = ST_TFI;
            phase_next      = PH_IDLE;
          end else begin
            data_sum_next = b;
            phase_next    = PH_CMD;
          end
        end
        PH_CMD: begin
          if ({1'b0, b} != cmd_want) begin
            result.done_res = 1'b1;
            result.status   = ST_CMD;
            phase_next      = PH_IDLE;
          end else begin
            data_sum_next = data_sum_add;
            phase_next    = (remaining_count != '0) ? PH_DATA : PH_DCS;
          end
        end
        PH_DATA: begin
          result.data_valid    = 1'b1;
          result.data_byte     = b;
          data_sum_next        = data_sum_add;
          remaining_count_next = remaining_dec;
          if (remaining_dec == '0) begin
            phase_next = PH_DCS;
          end
        end
        PH_DCS: begin
          if (data_sum_add != 8'h00) begin
            result.done_res = 1'b1;
            result.status   = ST_DATA_CSUM;
            phase_next      = PH_IDLE;
          end else begin
            phase_next = PH_POST;
          end
        end
        PH_POST: begin
          result.done_res = 1'b1;
          phase_next      = PH_IDLE;
          if (b != BYTE_00) begin
            result.status = ST_POSTAMBLE;
          end else begin
            result.status      = ST_OK;
            result.payload_len = length_value;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A finished frame always leaves the parser waiting for a new start
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    fire && result.done_res |=> phase == PH_IDLE)
    else $error("parser not idle after frame end");

  // Payload bytes come only from the data phase of a running frame
  a_data_in_phase: assert property (@(posedge clk) disable iff (rst)
    fire && result.data_valid |-> phase == PH_DATA && !beat.frame_start)
    else $error("payload byte outside data phase");

  // The data phase never runs with an exhausted byte count
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> remaining_count != '0)
    else $error("data phase with zero remaining count");
`endif

endmodule

FILE: sim/tb_nfc_response_frame_parser_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nfc_response_frame_parser_core: response frame parser testbench
// Drives byte beats from a queue, predicts every result beat with a local
// parser model, and checks each result beat against the oldest prediction.
// Runs a short directed frame list, then random frames under several
// command / length limit settings and three idle regimes on both channels.
// ----------------------------------------------------------------------------
module tb_nfc_response_frame_parser_core;
  import nrfp_pkg::*;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  nrfp_in_if  rx_if ();
  nrfp_out_if res_if ();

  nfc_response_frame_parser_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rx        (rx_if),
    .res       (res_if)
  );

  always #10 clk = ~clk;

  // Directed bytes {rx_byte, frame_start}: a dropped idle byte, a bad start,
  // a one-byte payload frame with the long start code, an error frame and a
  // restart that ends in a preamble error.
  localparam logic [8:0] DIRECTED [23] = '{
    {8'hFF, 1'b0},
    {8'h01, 1'b1},
    {8'h00, 1'b1}, {8'h00, 1'b0}, {8'hFF, 1'b0}, {8'h03, 1'b0}, {8'hFD, 1'b0},
    {8'hD5, 1'b0}, {8'h01, 1'b0}, {8'hFF, 1'b0}, {8'h2B, 1'b0}, {8'h00, 1'b0},
    {8'h00, 1'b1}, {8'hFF, 1'b0}, {8'h01, 1'b0}, {8'hFF, 1'b0}, {8'hAA, 1'b0},
    {8'hBB, 1'b0}, {8'hCC, 1'b0},
    {8'h00, 1'b1}, {8'hFF, 1'b0}, {8'h00, 1'b1}, {8'h7F, 1'b0}
  };

  in_beat_t    pending_bytes[$];
  out_beat_t   expected_results[$];
  in_beat_t    drv_beat;
  out_beat_t   got_beat;
  out_beat_t   want_beat;
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned fed_bytes;
  int unsigned mismatches;

  // Parser model state and register copies
  phase_t      cur_phase;
  logic [15:0] rem_cnt;
  logic [15:0] len_val;
  logic [7:0]  len_sum;
  logic [7:0]  dat_sum;
  logic [1:0]  skip_cnt;
  logic [7:0]  exp_cmd_reg;
  logic [15:0] max_len_reg;

  // Next-state and result of the parser for one accepted byte
  function automatic out_beat_t parse_byte(input logic [7:0] b, input logic s);
    out_beat_t   r;
    logic        ends;
    logic        chk;
    status_t     fin;
    logic [15:0] lfield;
    logic [7:0]  s8;
    r = '0;
    ends = 1'b0;
    chk = 1'b0;
    fin = ST_OK;
    lfield = '0;
    if (s) begin
      if (b == BYTE_00) cur_phase = PH_PRE1;
      else begin ends = 1'b1; fin = ST_PREAMBLE; end
    end else begin
      case (cur_phase)
        PH_PRE1: begin
          if (b == BYTE_FF) cur_phase = PH_FORM1;
          else if (b == BYTE_00) cur_phase = PH_PRE2;
          else begin ends = 1'b1; fin = ST_PREAMBLE; end
        end
        PH_PRE2: begin
          if (b == BYTE_FF) cur_phase = PH_FORM1;
          else begin ends = 1'b1; fin = ST_PREAMBLE; end
        end
        PH_FORM1: begin
          len_sum = b;
          cur_phase = PH_FORM2;
        end
        PH_FORM2: begin
          if (len_sum == ERR_FORM && b == BYTE_FF) begin
            skip_cnt = 2'd0;
            cur_phase = PH_ESKIP;
          end else if (len_sum == BYTE_FF && b == BYTE_FF) begin
            cur_phase = PH_EXTHI;
          end else if ({1'b0, len_sum} + {1'b0, b} != 9'h100) begin
            ends = 1'b1; fin = ST_LEN_CSUM;
          end else begin
            lfield = {8'h00, len_sum};
            chk = 1'b1;
          end
        end
        PH_ESKIP: begin
          if (skip_cnt >= 2'd2) begin
            skip_cnt = 2'd0;
            ends = 1'b1; fin = ST_APP_ERR;
          end else begin
            skip_cnt = skip_cnt + 2'd1;
          end
        end
        PH_EXTHI: begin
          len_val = {8'h00, b};
          len_sum = b;
          cur_phase = PH_EXTLO;
        end
        PH_EXTLO: begin
          len_val = {len_val[7:0], b};
          len_sum = len_sum + b;
          cur_phase = PH_EXTLCS;
        end
        PH_EXTLCS: begin
          s8 = len_sum + b;
          if (s8 != 8'h00) begin ends = 1'b1; fin = ST_LEN_CSUM; end
          else begin lfield = len_val; chk = 1'b1; end
        end
        PH_TFI: begin
          if (b != TFI_RESP) begin ends = 1'b1; fin = ST_TFI; end
          else begin dat_sum = b; cur_phase = PH_CMD; end
        end
        PH_CMD: begin
          // expected code 255 needs 256 here, which no byte can match
          if ({1'b0, b} != {1'b0, exp_cmd_reg} + 9'd1) begin
            ends = 1'b1; fin = ST_CMD;
          end else begin
            dat_sum = dat_sum + b;
            cur_phase = (rem_cnt != 16'd0) ? PH_DATA : PH_DCS;
          end
        end
        PH_DATA: begin
          r.data_valid = 1'b1;
          r.data_byte = b;
          dat_sum = dat_sum + b;
          rem_cnt = rem_cnt - 16'd1;
          if (rem_cnt == 16'd0) cur_phase = PH_DCS;
        end
        PH_DCS: begin
          s8 = dat_sum + b;
          if (s8 != 8'h00) begin ends = 1'b1; fin = ST_DATA_CSUM; end
          else cur_phase = PH_POST;
        end
        PH_POST: begin
          if (b != BYTE_00) begin
            ends = 1'b1; fin = ST_POSTAMBLE;
          end else begin
            ends = 1'b1; fin = ST_OK;
            r.payload_len = len_val;
          end
        end
        default: cur_phase = PH_IDLE;
      endcase
    end
    // length bound, after the length checksum; short lengths fail too
    if (chk) begin
      if (lfield < 16'd2 || lfield - 16'd2 > max_len_reg) begin
        ends = 1'b1; fin = ST_TOO_LONG;
      end else begin
        len_val = lfield - 16'd2;
        rem_cnt = len_val;
        cur_phase = PH_TFI;
      end
    end
    if (ends) begin
      r.done_res = 1'b1;
      r.status = fin;
      cur_phase = PH_IDLE;
    end
    return r;
  endfunction

  // Driver: predicts on each accepted beat, then offers the next one
  always @(posedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
    end else begin
      if (rx_if.valid && rx_if.ready)
        expected_results.push_back(parse_byte(rx_if.rx_byte, rx_if.frame_start));
      if (!rx_if.valid || rx_if.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
          drv_beat = pending_bytes.pop_front();
          rx_if.valid <= 1'b1;
          rx_if.rx_byte <= drv_beat.rx_byte;
          rx_if.frame_start <= drv_beat.frame_start;
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks result beats in order, throttles ready
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got_beat = '{data_valid: res_if.data_valid, data_byte: res_if.data_byte,
                     done_res: res_if.done_res, status: status_t'(res_if.status),
                     payload_len: res_if.payload_len};
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat dv=%0b byte=%02h done=%0b st=%0d len=%0d",
                   $time, got_beat.data_valid, got_beat.data_byte, got_beat.done_res,
                   got_beat.status, got_beat.payload_len);
        end else begin
          want_beat = expected_results.pop_front();
          if (got_beat !== want_beat) begin
            mismatches++;
            $display("%0t: expected dv=%0b byte=%02h done=%0b st=%0d len=%0d, got dv=%0b byte=%02h done=%0b st=%0d len=%0d",
                     $time, want_beat.data_valid, want_beat.data_byte, want_beat.done_res,
                     want_beat.status, want_beat.payload_len, got_beat.data_valid,
                     got_beat.data_byte, got_beat.done_res, got_beat.status,
                     got_beat.payload_len);
          end
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Queue a byte sequence as one frame: start mark on its first byte
  task automatic push_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) pending_bytes.push_back('{rx_byte: seq[i], frame_start: (i == 0)});
    fed_bytes += seq.size();
  endtask

  // Random start code
  task automatic add_start(ref logic [7:0] fb[$]);
    fb.push_back(BYTE_00);
    if ($urandom_range(1)) fb.push_back(BYTE_00);
    fb.push_back(BYTE_FF);
  endtask

  // Mostly short payloads, now and then long ones or exactly the limit
  function automatic int unsigned pick_len();
    int unsigned r;
    int unsigned cap;
    r = $urandom_range(99);
    cap = (r < 70) ? 6 : (r < 90) ? 40 : 300;
    if (r >= 96 && max_len_reg <= 16'd300) return max_len_reg;
    return $urandom_range((max_len_reg < cap) ? max_len_reg : cap);
  endfunction

  // Well-formed frame with optional single-byte corruption or truncation
  task automatic send_frame(input int unsigned n, input bit corrupt, input bit trunc);
    logic [7:0]  fb[$];
    logic [15:0] lf;
    logic [7:0]  cmd;
    logic [7:0]  dsum;
    logic [7:0]  pb;
    int unsigned pos;
    lf = 16'(n + 2);
    add_start(fb);
    if (n > 253 || $urandom_range(3) == 0) begin
      fb.push_back(BYTE_FF);
      fb.push_back(BYTE_FF);
      fb.push_back(lf[15:8]);
      fb.push_back(lf[7:0]);
      fb.push_back(8'h00 - lf[15:8] - lf[7:0]);
    end else begin
      fb.push_back(lf[7:0]);
      fb.push_back(8'h00 - lf[7:0]);
    end
    cmd = exp_cmd_reg + 8'd1;
    dsum = TFI_RESP + cmd;
    fb.push_back(TFI_RESP);
    fb.push_back(cmd);
    for (int unsigned i = 0; i < n; i++) begin
      pb = 8'($urandom_range(255));
      dsum = dsum + pb;
      fb.push_back(pb);
    end
    fb.push_back(8'h00 - dsum);
    fb.push_back(BYTE_00);
    if (corrupt) begin
      pos = $urandom_range(fb.size() - 1, 1);
      fb[pos] = fb[pos] ^ 8'($urandom_range(255, 1));
    end
    if (trunc) begin
      pos = $urandom_range(fb.size() - 1, 1);
      while (fb.size() > pos) void'(fb.pop_back());
    end
    push_seq(fb);
  endtask

  // Header whose length is over the limit or below two, checksum intact
  task automatic send_bad_length();
    logic [7:0]  fb[$];
    logic [15:0] lf;
    if (max_len_reg <= 16'd65532 && $urandom_range(3) != 0)
      lf = $urandom_range(1) ? max_len_reg + 16'd3
                             : 16'($urandom_range(65535, max_len_reg + 3));
    else
      lf = 16'($urandom_range(1));
    add_start(fb);
    if (lf >= 16'd2 && lf <= 16'd255 && $urandom_range(1)) begin
      fb.push_back(lf[7:0]);
      fb.push_back(8'h00 - lf[7:0]);
    end else begin
      fb.push_back(BYTE_FF);
      fb.push_back(BYTE_FF);
      fb.push_back(lf[15:8]);
      fb.push_back(lf[7:0]);
      fb.push_back(8'h00 - lf[15:8] - lf[7:0]);
    end
    push_seq(fb);
  endtask

  // Wait until every queued byte is taken and every result beat checked
  task automatic drain();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || rx_if.valid || expected_results.size() != 0);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random phase under a fixed register setting and idle regime
  task automatic run_phase(input logic [7:0] cmd, input logic [15:0] lim,
                           input int unsigned s_idle, input int unsigned r_idle,
                           input int unsigned target);
    int unsigned k;
    logic [7:0]  fb[$];
    drain();
    reg_write(CFG_EXPECTED_COMMAND, {8'h00, cmd});
    reg_write(CFG_MAX_PAYLOAD_LEN, lim);
    exp_cmd_reg = cmd;
    max_len_reg = lim;
    send_idle = s_idle;
    recv_idle = r_idle;
    @(negedge clk);
    fed_bytes = 0;
    while (fed_bytes < target) begin
      k = $urandom_range(99);
      if (k < 60) begin
        send_frame(pick_len(), 1'b0, 1'b0);
      end else if (k < 75) begin
        send_frame(pick_len(), 1'b1, 1'b0);
      end else if (k < 82) begin
        send_frame(pick_len(), 1'b0, 1'b1);
      end else if (k < 87) begin
        // error frame: 01 FF then three skipped bytes
        fb.delete();
        add_start(fb);
        fb.push_back(ERR_FORM);
        fb.push_back(BYTE_FF);
        repeat (3) fb.push_back(8'($urandom_range(255)));
        push_seq(fb);
      end else if (k < 93) begin
        send_bad_length();
      end else begin
        // line noise, now and then with a start mark
        repeat ($urandom_range(4, 1))
          pending_bytes.push_back('{rx_byte: 8'($urandom_range(255)),
                                   frame_start: ($urandom_range(3) == 0)});
      end
    end
  endtask

  // Main sequence
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    rx_if.frame_start = 1'b0;
    res_if.ready = 1'b0;
    mismatches = 0;
    send_idle = 26;
    recv_idle = 70;
    cur_phase = PH_IDLE;
    rem_cnt = '0;
    len_val = '0;
    len_sum = '0;
    dat_sum = '0;
    skip_cnt = '0;
    exp_cmd_reg = 8'h00;
    max_len_reg = MAX_PAYLOAD_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // directed part runs on the reset register values
    foreach (DIRECTED[i]) pending_bytes.push_back(in_beat_t'(DIRECTED[i]));
    run_phase(8'($urandom_range(254)), MAX_PAYLOAD_RESET, 26, 70, 280);
    run_phase(8'd0, 16'd0, 26, 70, 280);
    run_phase(8'd254, 16'd65533, 70, 26, 290);
    run_phase(8'd255, 16'($urandom_range(40)), 70, 26, 280);
    run_phase(8'($urandom_range(254)), 16'd5, 0, 0, 290);
    run_phase(8'($urandom_range(254)), 16'($urandom_range(65533)), 0, 0, 290);
    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog
  initial begin
    #(64'd10_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
